// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file svds_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SVDS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset
`define SVDS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== src/svds_pkg.sv =====
// Shared types and constants of the sparse voxel density store.
// No dependencies.
package svds_pkg;

    localparam int MODE_W = 2;
    localparam int DENS_W = 32;
    localparam int LIDX_W = 18;
    localparam int CFG_W  = 7;
    localparam int CHUNK_SIZE_RESET = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic REG_CHUNK_SIZE = 1'b0;

    typedef struct packed {
        logic load;       // latch the input item
        logic div_step;   // one restoring division step on all lanes
        logic idx_a;      // sign fix, size squared
        logic idx_b;      // partial products of the local index
        logic idx_c;      // final local index sum
        logic rd;         // read key and value at addr
        logic wr_entry;   // write new key and value at addr
        logic wr_value;   // overwrite value at addr
        logic res_load;   // load the output register
        logic res_found;
        logic res_full;
        logic res_zero;   // all result fields zero
    } cmd_t;

    typedef struct packed {
        logic key_hit;    // read key equals item key
        logic out_free;   // output register can take a result
    } sts_t;

endpackage

// ===== src/sparse_voxel_density_store.sv =====
// Sequence: a write or read runs the serial division, the index steps (IDXA, IDXB, IDXC),
// then scans the entries in use, a read and a compare state per entry, up to a hit or the
// end of the used entries; clear and mode 3 go straight to the result state.
// Flow: one item at a time; the linear scan of the entry memory through its registered read
// port sets the rate, plus the serial divider.
// Reset (aresetn low, synchronous): store empty, chunk size 32, no result pending.
// The entry memory needs no clearing pass: the fill count marks which entries are live.
module sparse_voxel_density_store import svds_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int COORD_BITS = 21,
    parameter int MAX_CHUNK  = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration port, register 0 chunk_size at byte address 0
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input items
    input  logic             s_tvalid,
    output logic             s_tready,
    // s_tdata fields, low to high: coord_x, coord_y, coord_z, write_density, zero pad
    input  logic [((3*COORD_BITS+DENS_W+7)/8)*8-1:0] s_tdata,
    // s_tuser fields: mode
    input  logic [MODE_W-1:0] s_tuser,
    // result items
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_tdata fields, low to high: read_density, chunk_x, chunk_y, chunk_z, local_index, pad
    output logic [((DENS_W+3*COORD_BITS+LIDX_W+7)/8)*8-1:0] m_tdata,
    // m_tuser fields, low to high: found, table_full
    output logic [1:0]       m_tuser
);
    localparam int AW    = $clog2(CAPACITY);
    localparam int IN_W  = ((3*COORD_BITS+DENS_W+7)/8)*8;
    localparam int OUT_W = ((DENS_W+3*COORD_BITS+LIDX_W+7)/8)*8;

    cmd_t             cmd;
    sts_t             sts;
    logic [AW-1:0]    addr;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_value;

    // write strobe for chunk_size; a write there also empties the store
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CHUNK_SIZE);
    assign prdata = (paddr[2] == REG_CHUNK_SIZE) ? 32'(cfg_value) : 32'd0;

    svds_ctrl #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .AW         (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .addr     (addr)
    );

    svds_datapath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .MAX_CHUNK  (MAX_CHUNK),
        .AW         (AW),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_data  (pwdata[CFG_W-1:0]),
        .cfg_value (cfg_value),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .addr      (addr),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== src/svds_datapath.sv =====
// Datapath: chunk size register, three division lanes, local index, entry memory,
// output register. Depends on svds_pkg.
module svds_datapath import svds_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int COORD_BITS = 21,
    parameter int MAX_CHUNK  = 64,
    parameter int AW         = $clog2(CAPACITY),
    parameter int IN_W       = 96,
    parameter int OUT_W      = 120
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic [CFG_W-1:0]  cfg_value,
    input  logic [IN_W-1:0]   s_tdata,
    input  cmd_t              cmd,
    input  logic [AW-1:0]     addr,
    output sts_t              sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic [1:0]        m_tuser
);
    localparam int CB  = COORD_BITS;
    localparam int SW  = $clog2(MAX_CHUNK + 1);
    localparam int KW  = 3 * CB;
    localparam int SUMW = 3 * SW + 2;

    logic [CFG_W-1:0] size_raw_reg;
    logic [SW-1:0]    d;

    logic [CB-1:0]    coord_reg [3];
    logic [DENS_W-1:0] dens_reg;
    logic [CB-1:0]    q_reg [3];
    logic [SW-1:0]    r_reg [3];
    logic [CB-1:0]    cq_reg [3];
    logic [SW-1:0]    lr_reg [3];
    logic [2*SW-1:0]  dd_reg;
    logic [2*SW-1:0]  lyd_reg;
    logic [3*SW-1:0]  lzd_reg;
    logic [LIDX_W-1:0] lidx_reg;

    logic [KW-1:0]     key_mem [CAPACITY];
    logic [DENS_W-1:0] val_mem [CAPACITY];
    logic [KW-1:0]     key_rd_reg;
    logic [DENS_W-1:0] val_rd_reg;
    logic [KW-1:0]     item_key;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    logic [SUMW-1:0]   lidx_sum;

    // clamp chunk size to 1..MAX_CHUNK
    always_comb begin
        if (size_raw_reg == '0) begin
            d = SW'(1);
        end else if (size_raw_reg > CFG_W'(MAX_CHUNK)) begin
            d = SW'(MAX_CHUNK);
        end else begin
            d = size_raw_reg[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_raw_reg <= CFG_W'(CHUNK_SIZE_RESET);
        end else if (cfg_we) begin
            size_raw_reg <= cfg_data;
        end
    end

    assign cfg_value = size_raw_reg;
    assign item_key  = {coord_reg[0], coord_reg[1], coord_reg[2]};

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [CB-1:0] cin;
        logic [SW:0]   trial;
        logic          neg;
        logic          rnz;

        assign cin   = s_tdata[g*CB +: CB];
        assign trial = {r_reg[g], q_reg[g][CB-1]};
        assign neg   = coord_reg[g][CB-1];
        assign rnz   = (r_reg[g] != '0);

        always_ff @(posedge aclk) begin
            if (cmd.load) begin
                coord_reg[g] <= cin;
                q_reg[g]     <= cin[CB-1] ? (~cin + CB'(1)) : cin;
                r_reg[g]     <= '0;
            end else if (cmd.div_step) begin
                if (trial >= {1'b0, d}) begin
                    r_reg[g] <= SW'(trial - {1'b0, d});
                    q_reg[g] <= {q_reg[g][CB-2:0], 1'b1};
                end else begin
                    r_reg[g] <= trial[SW-1:0];
                    q_reg[g] <= {q_reg[g][CB-2:0], 1'b0};
                end
            end
            // floor correction for negative coordinates
            if (cmd.idx_a) begin
                if (neg && rnz) begin
                    cq_reg[g] <= ~q_reg[g];
                    lr_reg[g] <= d - r_reg[g];
                end else if (neg) begin
                    cq_reg[g] <= CB'(0) - q_reg[g];
                    lr_reg[g] <= r_reg[g];
                end else begin
                    cq_reg[g] <= q_reg[g];
                    lr_reg[g] <= r_reg[g];
                end
            end
        end
    end

    assign lidx_sum = SUMW'(lr_reg[0]) + SUMW'(lyd_reg) + SUMW'(lzd_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dens_reg <= s_tdata[KW +: DENS_W];
        end
        if (cmd.idx_a) begin
            dd_reg <= d * d;
        end
        if (cmd.idx_b) begin
            lyd_reg <= lr_reg[1] * d;
            lzd_reg <= (3*SW)'(lr_reg[2]) * (3*SW)'(dd_reg);
        end
        if (cmd.idx_c) begin
            lidx_reg <= lidx_sum[LIDX_W-1:0];
        end
    end

    // entry memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_entry) begin
            key_mem[addr] <= item_key;
        end
        if (cmd.wr_entry || cmd.wr_value) begin
            val_mem[addr] <= dens_reg;
        end
        if (cmd.rd) begin
            key_rd_reg <= key_mem[addr];
            val_rd_reg <= val_mem[addr];
        end
    end

    assign sts.key_hit  = (key_rd_reg == item_key);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            if (cmd.res_zero) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= '0;
            end else begin
                m_tdata_reg <= OUT_W'({lidx_reg, cq_reg[2], cq_reg[1], cq_reg[0],
                                       (cmd.res_found ? val_rd_reg : DENS_W'(0))});
                m_tuser_reg <= {cmd.res_full, cmd.res_found};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== src/svds_ctrl.sv =====
// Controller: sequences division, index build, linear search and update.
// Depends on svds_pkg.
module svds_ctrl import svds_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int COORD_BITS = 21,
    parameter int AW         = $clog2(CAPACITY)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MODE_W-1:0] s_mode,
    input  sts_t              sts,
    output cmd_t              cmd,
    output logic [AW-1:0]     addr
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SC = $clog2(COORD_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_IDXA, ST_IDXB, ST_IDXC, ST_SRD, ST_SCMP, ST_DONE
    } state_t;

    state_t          state_reg;
    mode_t           mode_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   idx_reg;
    logic [SC-1:0]   step_reg;
    logic            found_reg, full_reg, zero_reg;
    logic            accept;
    logic            at_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign at_end   = (idx_reg == count_reg);

    always_comb begin
        cmd       = '0;
        cmd.load  = accept;
        addr      = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE: ;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_IDXA: cmd.idx_a = 1'b1;
            ST_IDXB: cmd.idx_b = 1'b1;
            ST_IDXC: cmd.idx_c = 1'b1;
            ST_SRD: begin
                if (at_end) begin
                    addr = count_reg[AW-1:0];
                    cmd.wr_entry = (mode_reg == MODE_WRITE) &&
                                   (count_reg != CW'(CAPACITY));
                end else begin
                    cmd.rd = 1'b1;
                end
            end
            ST_SCMP: cmd.wr_value = sts.key_hit && (mode_reg == MODE_WRITE);
            ST_DONE: begin
                cmd.res_load  = sts.out_free;
                cmd.res_found = found_reg;
                cmd.res_full  = full_reg;
                cmd.res_zero  = zero_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_NONE;
            count_reg <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
            zero_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                count_reg <= '0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        mode_reg  <= mode_t'(s_mode);
                        found_reg <= 1'b0;
                        full_reg  <= 1'b0;
                        idx_reg   <= '0;
                        step_reg  <= SC'(COORD_BITS);
                        if (s_mode == MODE_CLEAR) begin
                            count_reg <= '0;
                            zero_reg  <= 1'b1;
                            state_reg <= ST_DONE;
                        end else if (s_mode == MODE_NONE) begin
                            zero_reg  <= 1'b1;
                            state_reg <= ST_DONE;
                        end else begin
                            zero_reg  <= 1'b0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    step_reg <= step_reg - SC'(1);
                    if (step_reg == SC'(1)) begin
                        state_reg <= ST_IDXA;
                    end
                end
                ST_IDXA: state_reg <= ST_IDXB;
                ST_IDXB: state_reg <= ST_IDXC;
                ST_IDXC: state_reg <= ST_SRD;
                ST_SRD: begin
                    if (at_end) begin
                        if (mode_reg == MODE_WRITE) begin
                            if (count_reg != CW'(CAPACITY)) begin
                                count_reg <= count_reg + CW'(1);
                            end else begin
                                full_reg <= 1'b1;
                            end
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_SCMP;
                    end
                end
                ST_SCMP: begin
                    if (sts.key_hit) begin
                        found_reg <= (mode_reg == MODE_READ);
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_SRD;
                    end
                end
                ST_DONE: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/svds_checker.sv =====
// Port-level checker for the sparse voxel density store, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module svds_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [1:0] m_tuser
);
    // one item at a time: busy right after taking an item
    `SVDS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a result is never both a read hit and a dropped write
    `SVDS_ASSERT_IMP(a_found_full_excl, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    // stalled result flags hold
    `SVDS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tuser))
endmodule

bind sparse_voxel_density_store svds_checker u_svds_checker (.*);

// ===== tb/tb_sparse_voxel_density_store.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of sparse_voxel_density_store: stream items in, predict each
// result with a local density map, compare every result field. Depends on svds_pkg.
module tb_sparse_voxel_density_store;
    import svds_pkg::*;

    localparam int CAPACITY   = 1024;
    localparam int COORD_BITS = 21;
    localparam int MAX_CHUNK  = 64;
    localparam int S_W = ((3*COORD_BITS+DENS_W+7)/8)*8;
    localparam int M_W = ((DENS_W+3*COORD_BITS+LIDX_W+7)/8)*8;
    localparam logic [2:0] ADDR_CHUNK_SIZE = {REG_CHUNK_SIZE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;
    localparam int C_MIN = -(1 << (COORD_BITS-1));
    localparam int C_MAX = (1 << (COORD_BITS-1)) - 1;

    typedef struct {
        mode_t                 mode;
        logic signed [20:0]    x, y, z;
        logic [DENS_W-1:0]     dens;
    } access_t;

    typedef struct {
        logic                  found;
        logic [DENS_W-1:0]     dens;
        logic                  full;
        logic [20:0]           cx, cy, cz;
        logic [LIDX_W-1:0]     lidx;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;
    logic s_tvalid = 1'b0, s_tready;
    logic [S_W-1:0] s_tdata = '0;   // coord_x, coord_y, coord_z, write_density, pad
    logic [MODE_W-1:0] s_tuser = '0; // mode
    logic m_tvalid, m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;        // read_density, chunk_x, chunk_y, chunk_z, local_index, pad
    logic [1:0] m_tuser;            // found, table_full

    sparse_voxel_density_store #(
        .CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS), .MAX_CHUNK(MAX_CHUNK)
    ) i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // local copy of the store and its configuration
    logic [DENS_W-1:0] density_map[logic [62:0]];
    int unsigned       chunk_cfg = CHUNK_SIZE_RESET;

    access_t pending_items[$];
    answer_t expected_answers[$];
    access_t coord_pool[$];
    int  errors = 0, results_seen = 0, hits_seen = 0, fulls_seen = 0;
    bit  send_gaps = 1'b1, recv_gaps = 1'b1;
    int  rx_hold_req = 0;

    function automatic answer_t predict_access(access_t a);
        answer_t r;
        longint d, c[3], q, m, l[3];
        logic [62:0] key;
        r = '{default: '0};
        if (a.mode == MODE_CLEAR) begin
            density_map.delete();
            return r;
        end
        if (a.mode == MODE_NONE) return r;
        d = (chunk_cfg < 1) ? 1 : (chunk_cfg > MAX_CHUNK) ? MAX_CHUNK : chunk_cfg;
        c[0] = a.x; c[1] = a.y; c[2] = a.z;
        for (int i = 0; i < 3; i++) begin
            q = c[i] / d;
            m = c[i] % d;
            if (m < 0) begin
                q -= 1;
                m += d;
            end
            l[i] = m;
            c[i] = q;
        end
        r.cx = c[0][20:0];
        r.cy = c[1][20:0];
        r.cz = c[2][20:0];
        r.lidx = LIDX_W'(l[0] + l[1]*d + l[2]*d*d);
        key = {a.x, a.y, a.z};
        if (a.mode == MODE_WRITE) begin
            if (density_map.exists(key) || density_map.num() < CAPACITY)
                density_map[key] = a.dens;
            else
                r.full = 1'b1;
        end else if (density_map.exists(key)) begin
            r.found = 1'b1;
            r.dens = density_map[key];
        end
        return r;
    endfunction

    // Driver: offer the next pending item once the gap drawn for it has run out.
    int send_gap = 0;
    always @(posedge aclk) begin
        access_t a;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_answers.push_back(predict_access(
                    '{mode_t'(s_tuser), s_tdata[20:0], s_tdata[41:21], s_tdata[62:42],
                      s_tdata[94:63]}));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    a = pending_items.pop_front();
                    s_tdata <= {1'b0, a.dens, a.z, a.y, a.x};
                    s_tuser <= a.mode;
                    s_tvalid <= 1'b1;
                    send_gap = send_gaps ? $urandom_range(0, 11) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation, then pace m_tready.
    int recv_stall = 0, rx_hold = 0;
    always @(posedge aclk) begin
        answer_t e;
        logic ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_answers.size() == 0) begin
                    errors++;
                    $display("%0t: result with no item pending, got %h/%b", $time,
                             m_tdata, m_tuser);
                end else begin
                    e = expected_answers.pop_front();
                    hits_seen += e.found;
                    fulls_seen += e.full;
                    if ({e.lidx, e.cz, e.cy, e.cx, e.dens} !== m_tdata[112:0] ||
                        {e.full, e.found} !== m_tuser || m_tdata[M_W-1:113] !== '0) begin
                        errors++;
                        $display("%0t: mismatch expected lidx=%h c=%h,%h,%h dens=%h full=%b found=%b",
                                 $time, e.lidx, e.cz, e.cy, e.cx, e.dens, e.full, e.found);
                        $display("%0t:          actual   lidx=%h c=%h,%h,%h dens=%h full=%b found=%b",
                                 $time, m_tdata[112:95], m_tdata[94:74], m_tdata[73:53],
                                 m_tdata[52:32], m_tdata[31:0], m_tuser[1], m_tuser[0]);
                    end
                end
                recv_stall = recv_gaps ? $urandom_range(0, 11) : 0;
            end
            if (rx_hold_req > 0) begin
                rx_hold = rx_hold_req;
                rx_hold_req = 0;
            end
            ready_next = 1'b0;
            if (rx_hold > 0) rx_hold--;
            else if (recv_stall > 0) recv_stall--;
            else ready_next = 1'b1;
            m_tready <= ready_next;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register in a setup and an access phase; only called while drained.
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_CHUNK_SIZE) begin
            chunk_cfg = data[6:0];
            density_map.delete();
        end
    endtask

    task automatic queue_access(mode_t md, int x, int y, int z, logic [31:0] dens);
        access_t a;
        a = '{md, x[20:0], y[20:0], z[20:0], dens};
        pending_items.push_back(a);
        if (md == MODE_WRITE) begin
            coord_pool.push_back(a);
            if (coord_pool.size() > 24) void'(coord_pool.pop_front());
        end
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 70) - 35;
            1: return C_MIN;
            2: return C_MAX;
            3: return $urandom_range(0, 300) - 150;
            default: return int'($signed(21'($urandom)));
        endcase
    endfunction

    // Draw one random item: mostly writes and reads around recently written voxels.
    task automatic queue_random();
        access_t p;
        int sel, x, y, z;
        mode_t md;
        sel = $urandom_range(0, 99);
        md = (sel < 47) ? MODE_WRITE : (sel < 95) ? MODE_READ :
             (sel < 98) ? MODE_CLEAR : MODE_NONE;
        if (coord_pool.size() > 0 && $urandom_range(0, 99) < 55) begin
            p = coord_pool[$urandom_range(0, coord_pool.size()-1)];
            x = p.x; y = p.y; z = p.z;
            if ($urandom_range(0, 3) == 0) x += $urandom_range(0, 2) - 1;
        end else begin
            x = pick_coord(); y = pick_coord(); z = pick_coord();
        end
        queue_access(md, x, y, z, $urandom);
    endtask

    initial begin
        int sizes[12] = '{1, 64, 32, 0, 127, 2, 3, 7, 16, 33, 63, 5};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every mode, negative remainders, overwrite, miss, clear
        queue_access(MODE_WRITE, C_MIN, C_MIN, C_MIN, 32'hFFFF_FFFF);
        queue_access(MODE_WRITE, C_MAX, C_MAX, C_MAX, 32'h0000_0000);
        queue_access(MODE_WRITE, -1, -32, -33, 32'h3F80_0000);
        queue_access(MODE_READ, C_MIN, C_MIN, C_MIN, 32'h0);
        queue_access(MODE_READ, C_MAX, C_MAX, C_MAX, 32'hFFFF_FFFF);
        queue_access(MODE_READ, -1, -32, -33, 32'h0);
        queue_access(MODE_READ, 0, 0, 0, 32'h0);
        queue_access(MODE_WRITE, -1, -32, -33, 32'hA5A5_5A5A);
        queue_access(MODE_READ, -1, -32, -33, 32'h0);
        queue_access(MODE_WRITE, 31, 32, 0, 32'h1234_5678);
        queue_access(MODE_READ, 31, 32, 0, 32'h0);
        queue_access(MODE_NONE, 5, 6, 7, 32'hDEAD_BEEF);
        queue_access(MODE_READ, C_MIN, C_MIN, C_MIN, 32'h0);
        queue_access(MODE_CLEAR, C_MAX, C_MIN, 0, 32'hFFFF_FFFF);
        queue_access(MODE_READ, C_MAX, C_MAX, C_MAX, 32'h0);
        queue_access(MODE_READ, 31, 32, 0, 32'h0);
        wait_drained();

        // unmapped register: store must survive it
        queue_access(MODE_WRITE, 9, 9, 9, 32'h0BAD_F00D);
        wait_drained();
        reg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        queue_access(MODE_READ, 9, 9, 9, 32'h0);
        wait_drained();

        // fill every entry, then push past capacity
        reg_write(ADDR_CHUNK_SIZE, 32'd64);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            queue_access(MODE_WRITE, i - 512, -i, i * 3, $urandom);
        queue_access(MODE_WRITE, 600, 1, 1, 32'h7777_7777);
        queue_access(MODE_WRITE, 0, -512, 1536, 32'h5555_AAAA);
        queue_access(MODE_READ, 0, -512, 1536, 32'h0);
        queue_access(MODE_READ, 600, 1, 1, 32'h0);
        queue_access(MODE_CLEAR, 0, 0, 0, 32'h0);
        queue_access(MODE_WRITE, 600, 1, 1, 32'h7777_7777);
        queue_access(MODE_READ, 600, 1, 1, 32'h0);
        wait_drained();

        // random phases, one chunk size each; gaps on both sides or off on one side
        for (int ph = 0; ph < 12; ph++) begin
            reg_write(ADDR_CHUNK_SIZE, {25'($urandom_range(0, 33554431)), 7'(sizes[ph])});
            coord_pool.delete();
            send_gaps = (ph % 4) != 1;
            recv_gaps = (ph % 4) != 2;
            if (ph == 3) rx_hold_req = 500;
            for (int i = 0; i < 13; i++) queue_random();
            wait_drained();
        end

        $display("covered %0d results, %0d read hits, %0d table-full drops",
                 results_seen, hits_seen, fulls_seen);
        $display("chunk sizes 0 to 127 incl. clamping, store fill to capacity, clears, stalls");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
